@@ sv/u2u_pkg.sv @@
// Package for the UTF-8 to UTF-16 transcoder: item types, job and status
// structs, code constants and the lead byte length decoder. No dependencies.
package u2u_pkg;

    localparam logic [15:0] BadUnit    = 16'h0023;   // '#'
    localparam logic [15:0] SurrHiBase = 16'hD800;
    localparam logic [15:0] SurrLoBase = 16'hDC00;
    localparam logic [20:0] SuppBase   = 21'h010000;
    localparam logic [20:0] MaxCp      = 21'h10FFFF;
    localparam int          QueueDepth = 2;
    localparam int          QueuePtrW  = $clog2(QueueDepth);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [15:0] out_unit;
        logic        last_of_run;
        logic        string_done;
    } t_out_item;

    // One decode job: up to four bytes, byte count 1..4, end-of-string flag.
    typedef struct packed {
        logic [3:0][7:0] seq_bytes;
        logic [2:0]      byte_cnt;
        logic            last;
    } t_job;

    typedef struct packed {
        logic [1:0] held_count;
        logic [2:0] seq_len;
    } t_front_status;

    typedef struct packed {
        logic       lo_pend;
        logic [2:0] pos;
    } t_back_status;

    // Sequence length from the lead byte's top five bits; 0 = invalid lead.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        unique case (b[7:3]) inside
            [5'd0:5'd15]:  len = 3'd1;
            [5'd16:5'd23]: len = 3'd0;
            [5'd24:5'd27]: len = 3'd2;
            [5'd28:5'd29]: len = 3'd3;
            5'd30:         len = 3'd4;
            default:       len = 3'd0;
        endcase
        return len;
    endfunction

endpackage

@@ sv/u2u_front.sv @@
// Front end of the transcoder: collects the bytes of a multi-byte sequence
// and hands complete (or end-truncated) groups to the job queue. Uses u2u_pkg.
module u2u_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  u2u_pkg::t_in_item     i_item,
    output logic                  o_job_push,
    output u2u_pkg::t_job         o_job,
    output u2u_pkg::t_front_status o_status
);
    import u2u_pkg::*;

    logic [2:0] r_held_count;
    logic [2:0] r_seq_len;
    logic [7:0] r_held [3];

    logic [2:0] n_cnt;
    logic [2:0] b_len;
    logic       hold_lead;
    logic       hold_cont;

    assign n_cnt     = r_held_count + 3'd1;
    assign b_len     = lead_len(i_item.in_byte);
    // first byte of a multi-byte sequence, or a continuation still short
    assign hold_lead = !i_item.end_of_string && (r_held_count == 3'd0) && (b_len >= 3'd2);
    assign hold_cont = !i_item.end_of_string && (r_held_count != 3'd0) && (n_cnt < r_seq_len);

    assign o_job_push = i_accept && !hold_lead && !hold_cont;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_job.seq_bytes[i] = (r_held_count == 3'(i)) ? i_item.in_byte : r_held[i];
        end
        o_job.seq_bytes[3] = i_item.in_byte;
        o_job.byte_cnt     = n_cnt;
        o_job.last         = i_item.end_of_string;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= 3'd0;
            r_seq_len    <= 3'd0;
        end else if (i_accept) begin
            if (hold_lead) begin
                r_held_count <= 3'd1;
                r_seq_len    <= b_len;
            end else if (hold_cont) begin
                r_held_count <= n_cnt;
            end else begin
                r_held_count <= 3'd0;
                r_seq_len    <= 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (hold_lead || hold_cont)) begin
            r_held[r_held_count[1:0]] <= i_item.in_byte;
        end
    end

    assign o_status.held_count = r_held_count[1:0];
    assign o_status.seq_len    = r_seq_len;

endmodule

@@ sv/u2u_queue.sv @@
// Two-entry job queue between transcoder front and back end.
// Uses u2u_pkg.
module u2u_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  u2u_pkg::t_job i_job,
    input  logic          i_pop,
    output u2u_pkg::t_job o_head,
    output logic          o_full,
    output logic          o_empty
);
    import u2u_pkg::*;

    t_job                 r_entries [QueueDepth];
    logic [QueuePtrW-1:0] r_wr_ptr;
    logic [QueuePtrW-1:0] r_rd_ptr;
    logic [QueuePtrW:0]   r_count;

    assign o_full  = (r_count == (QueuePtrW + 1)'(QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_head  = r_entries[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ sv/u2u_back.sv @@
// Back end: walks the head job one code unit per cycle unless stalled,
// re-decoding truncated groups, into a one-entry output register. Uses u2u_pkg.
module u2u_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  u2u_pkg::t_job         i_head,
    input  logic                  i_head_empty,
    output logic                  o_head_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output u2u_pkg::t_out_item    o_item,
    output u2u_pkg::t_back_status o_status
);
    import u2u_pkg::*;

    logic [2:0]  r_pos;
    logic        r_lo_pend;
    logic [15:0] r_lo_unit;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        advance;
    logic        emit;
    logic [1:0]  idx0, idx1, idx2, idx3;
    logic [7:0]  lead;
    logic [5:0]  c1, c2, c3;
    logic [2:0]  len;
    logic [2:0]  remain;
    logic        fits;
    logic [20:0] cp;
    logic [20:0] v;
    logic [15:0] unit;
    logic [2:0]  n_pos;
    logic        n_lo_pend;
    logic [15:0] n_lo_unit;
    logic        done;

    assign idx0   = r_pos[1:0];
    assign idx1   = idx0 + 2'd1;
    assign idx2   = idx0 + 2'd2;
    assign idx3   = idx0 + 2'd3;
    assign lead   = i_head.seq_bytes[idx0];
    assign c1     = i_head.seq_bytes[idx1][5:0];
    assign c2     = i_head.seq_bytes[idx2][5:0];
    assign c3     = i_head.seq_bytes[idx3][5:0];
    assign len    = lead_len(lead);
    assign remain = i_head.byte_cnt - r_pos;
    assign fits   = (len != 3'd0) && (len <= remain);

    always_comb begin
        unique case (len)
            3'd1:    cp = {14'd0, lead[6:0]};
            3'd2:    cp = {10'd0, lead[4:0], c1};
            3'd3:    cp = {5'd0, lead[3:0], c1, c2};
            3'd4:    cp = {lead[2:0], c1, c2, c3};
            default: cp = '0;
        endcase
    end

    assign v = cp - SuppBase;

    always_comb begin
        unit      = BadUnit;
        n_pos     = r_pos;
        n_lo_pend = 1'b0;
        n_lo_unit = r_lo_unit;
        if (r_lo_pend) begin
            unit = r_lo_unit;
        end else if (!fits) begin
            n_pos = r_pos + 3'd1;
        end else begin
            n_pos = r_pos + len;
            if (cp < SuppBase) begin
                unit = cp[15:0];
            end else if (cp <= MaxCp) begin
                unit      = SurrHiBase + {6'd0, v[19:10]};
                n_lo_pend = 1'b1;
                n_lo_unit = SurrLoBase + {6'd0, v[9:0]};
            end
        end
        done = !n_lo_pend && (n_pos >= i_head.byte_cnt);
    end

    assign advance    = !r_out_valid || i_pop;
    assign emit       = advance && !i_head_empty;
    assign o_head_pop = emit && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 3'd0;
            r_lo_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_pos       <= done ? 3'd0 : n_pos;
            r_lo_pend   <= n_lo_pend;
            r_out_valid <= 1'b1;
        end else if (advance) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_lo_unit         <= n_lo_unit;
            r_out.out_unit    <= unit;
            r_out.last_of_run <= done;
            r_out.string_done <= done && i_head.last;
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_item           = r_out;
    assign o_status.lo_pend = r_lo_pend;
    assign o_status.pos     = r_pos;

endmodule

@@ sv/utf8_to_utf16_transcoder.sv @@
// Top level of the UTF-8 to UTF-16 transcoder: front end, job queue, back end.
// Depends on u2u_pkg, u2u_front, u2u_queue and u2u_back.
//
// Streams UTF-8 bytes in and UTF-16 code units out, both sides as queues.
// A byte is a transfer on push while full is low; a unit is a transfer on pop
// while empty is low. The front end takes one byte every cycle while full is
// low and collects the bytes of a multi-byte sequence; a finished group (a
// single byte, a complete sequence, or whatever is held when end_of_string
// arrives) becomes one job in a two-entry queue. The back end walks the head
// job and produces one code unit per cycle while its output register is empty
// or popped, so the result side delivers one unit per cycle while pop is high:
// ASCII text runs at one byte in and one unit out every cycle without stalls,
// and a four-byte sequence gives its surrogate pair as two units. A byte that
// completes a group is queued as a job, and its unit then passes the output
// register to the result ports. full goes high only when both queue entries
// are occupied, which happens when the result side stalls or when a group
// expands to more units than it had bytes (a truncated tail decoded again).
// Decoding: the lead byte's top five bits set the length; continuation bytes
// are masked to six bits without checking; invalid leads, leads cut short by
// end_of_string and codepoints above 0x10FFFF give '#'. last_of_run marks the
// last unit caused by a byte; string_done marks the last unit of the string.
module utf8_to_utf16_transcoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  u2u_pkg::t_in_item  i_data,
    output logic               empty,
    input  logic               pop,
    output u2u_pkg::t_out_item o_data
);
    import u2u_pkg::*;

    logic          accept;
    logic          job_push;
    t_job          job;
    t_job          head;
    logic          head_empty;
    logic          head_pop;
    t_front_status front_status;
    t_back_status  back_status;

    assign accept = push && !full;

    u2u_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_data),
        .o_job_push (job_push),
        .o_job      (job),
        .o_status   (front_status)
    );

    // full is the queue's full flag; a holding byte needs no entry but
    // readiness stays independent of the byte's value
    u2u_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job),
        .i_pop   (head_pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (head_empty)
    );

    u2u_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_empty (head_empty),
        .o_head_pop   (head_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_item       (o_data),
        .o_status     (back_status)
    );

    // end of string always closes the group held in the front end
    a_eos_clears_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_data.end_of_string) |=>
            (front_status.held_count == 2'd0 && front_status.seq_len == 3'd0))
        else $error("front end still holds bytes after end of string");

    // a pending low surrogate means its high half sits in the output register
    a_lo_after_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.lo_pend |-> (!empty && o_data.out_unit[15:10] == 6'b110110
            && !o_data.last_of_run))
        else $error("low surrogate pending without high surrogate shown");

    // string end is always the final unit of its run
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_data.string_done) |-> o_data.last_of_run)
        else $error("string_done without last_of_run");

    // the back end never walks past the job it holds
    a_pos_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!head_empty && !back_status.lo_pend) |-> (back_status.pos < head.byte_cnt))
        else $error("back end position beyond job length");

endmodule

@@ tb/tb_utf8_to_utf16_transcoder.sv @@
// Testbench for utf8_to_utf16_transcoder: a self-checking run of directed
// and random UTF-8 strings against a built-in UTF-8 to UTF-16 model.
// Depends on u2u_pkg and the transcoder RTL.
module tb_utf8_to_utf16_transcoder;

    import u2u_pkg::*;

    // Expected UTF-16 units, built byte by byte from accepted transfers and
    // matched in order against the units that come out of the block.
    class utf16_scoreboard;
        t_out_item  expected_units[$];
        logic [7:0] held[3];        // bytes of an unfinished sequence
        logic [1:0] held_cnt;
        logic [2:0] want_len;       // length announced by the held lead
        t_out_item  step_units[3];  // units caused by the current byte
        int         step_cnt;
        int         bytes_in;
        int         units_checked;
        int         errors;

        function new();
            held_cnt      = '0;
            want_len      = '0;
            step_cnt      = 0;
            bytes_in      = 0;
            units_checked = 0;
            errors        = 0;
        endfunction

        // Sequence length from a lead byte's leading ones; 0 for a continuation or 11111xxx.
        function int seq_len_of(logic [7:0] b);
            casez (b)
                8'b0???????: return 1;
                8'b110?????: return 2;
                8'b1110????: return 3;
                8'b11110???: return 4;
                default:     return 0;
            endcase
        endfunction

        function void emit_unit(logic [15:0] u);
            if (step_cnt < 3) begin
                step_units[step_cnt].out_unit    = u;
                step_units[step_cnt].last_of_run = 1'b0;
                step_units[step_cnt].string_done = 1'b0;
                step_cnt++;
            end
        endfunction

        // Takes one accepted byte and appends the units it completes.
        function void transcode_byte(t_in_item it);
            logic [7:0]  grp[4];
            logic [20:0] cp;
            logic [20:0] off;
            logic [7:0]  mask;
            int          n;
            int          pos;
            int          len;
            int          k;
            bytes_in++;
            n = held_cnt;
            for (k = 0; k < n; k++) grp[k] = held[k];
            grp[n] = it.in_byte;
            n++;

            // Still collecting a multi-byte sequence: nothing comes out yet.
            if (!it.end_of_string) begin
                if (n == 1) begin
                    len = seq_len_of(it.in_byte);
                    if (len >= 2) begin
                        held[0]  = it.in_byte;
                        held_cnt = 2'd1;
                        want_len = 3'(len);
                        return;
                    end
                end else if (n < want_len && n <= 3) begin
                    held[n-1] = it.in_byte;
                    held_cnt  = 2'(n);
                    return;
                end
            end

            // Decode the group; a lead cut short gives '#' and the rest is
            // decoded again from the next byte.
            step_cnt = 0;
            pos      = 0;
            while (pos < n) begin
                len = seq_len_of(grp[pos]);
                if (len == 0 || len > n - pos) begin
                    emit_unit(BadUnit);
                    pos++;
                end else begin
                    mask = (len == 1) ? 8'h7F : (8'hFF >> (len + 1));
                    cp   = {13'd0, grp[pos] & mask};
                    for (k = 1; k < len; k++) cp = {cp[14:0], grp[pos+k][5:0]};
                    if (cp < SuppBase) begin
                        emit_unit(cp[15:0]);
                    end else if (cp <= MaxCp) begin
                        off = cp - SuppBase;
                        emit_unit(SurrHiBase + {6'd0, off[19:10]});
                        emit_unit(SurrLoBase + {6'd0, off[9:0]});
                    end else begin
                        emit_unit(BadUnit);
                    end
                    pos += len;
                end
            end
            held_cnt = '0;
            want_len = '0;

            if (step_cnt > 0) begin
                step_units[step_cnt-1].last_of_run = 1'b1;
                step_units[step_cnt-1].string_done = it.end_of_string;
            end
            for (k = 0; k < step_cnt; k++) expected_units.push_back(step_units[k]);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] ERROR %s", $time, msg);
        endtask

        task match_unit(t_out_item got);
            t_out_item want;
            units_checked++;
            if (expected_units.size() == 0) begin
                report($sformatf("unit %04h arrived with nothing expected", got.out_unit));
                return;
            end
            want = expected_units.pop_front();
            if (got.out_unit !== want.out_unit)
                report($sformatf("out_unit %04h, expected %04h",
                                 got.out_unit, want.out_unit));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("last_of_run %b on unit %04h, expected %b",
                                 got.last_of_run, want.out_unit, want.last_of_run));
            if (got.string_done !== want.string_done)
                report($sformatf("string_done %b on unit %04h, expected %b",
                                 got.string_done, want.out_unit, want.string_done));
        endtask
    endclass

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 60;
    localparam int LONG_HOLD    = 80;   // cycles the result side holds off

    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      push     = 1'b0;
    logic      pop      = 1'b0;
    logic      full;
    logic      empty;
    t_in_item  in_item  = '0;
    t_out_item out_item;

    utf16_scoreboard sb;
    logic [7:0] text[$];        // string being sent
    bit         steady      = 1'b0;   // no idling on either side
    bit         hold_request = 1'b0;  // asks the result side for a long stall
    int         strings     = 0;
    int         cycles      = 0;

    utf8_to_utf16_transcoder i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .push    (push),
        .full    (full),
        .i_data  (in_item),
        .empty   (empty),
        .pop     (pop),
        .o_data  (out_item)
    );

    always #10 clk = ~clk;

    // Watchdog: a hang or a lost unit ends the run here.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d units still expected",
                     cycles, sb.expected_units.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Transfers are seen on pre-edge values, so driver NBAs at the same
    // edge cannot race with what is sampled here.
    always @(posedge clk) begin
        if (rst_n && push && !full) sb.transcode_byte(in_item);
        if (rst_n && pop && !empty) sb.match_unit(out_item);
    end

    // Result side: random stall before each unit, plus one long hold-off
    // on request so the block backs up and raises full.
    initial begin : unit_sink
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = steady ? 0 : $urandom_range(0, 14);
            if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    // One byte transfer; push stays high when the next byte follows at once.
    task automatic offer_byte(input logic [7:0] b, input logic eos);
        t_in_item nxt;
        int       gap;
        nxt.in_byte       = b;
        nxt.end_of_string = eos;
        gap = steady ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= nxt;
        do @(posedge clk); while (full);
    endtask

    task automatic send_text();
        int k;
        for (k = 0; k < text.size(); k++) offer_byte(text[k], k == text.size() - 1);
        strings++;
    endtask

    // Sender goes quiet until every predicted unit has come out.
    task automatic wait_all_units();
        push <= 1'b0;
        do @(posedge clk); while (sb.expected_units.size() != 0);
    endtask

    // Mostly well-formed characters with random payload bits, some raw noise
    // bytes, and now and then a tail cut off so the string ends mid-sequence.
    task automatic build_random_text();
        int         chars;
        int         len;
        int         k;
        logic [2:0] top;
        text.delete();
        chars = $urandom_range(1, 6);
        repeat (chars) begin
            if ($urandom_range(0, 9) < 2) begin
                text.push_back(8'($urandom_range(0, 255)));
            end else begin
                len = $urandom_range(1, 4);
                case (len)
                    1: text.push_back({1'b0, 7'($urandom)});
                    2: text.push_back({3'b110, 5'($urandom)});
                    3: text.push_back({4'b1110, 4'($urandom)});
                    default: begin
                        // F5..F7 leads decode past the top codepoint
                        top = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                                          : 3'($urandom_range(0, 4));
                        text.push_back({5'b11110, top});
                    end
                endcase
                for (k = 1; k < len; k++) text.push_back({2'b10, 6'($urandom)});
            end
        end
        if (text.size() > 1 && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2))
                if (text.size() > 1) text.delete(text.size() - 1);
        end
    endtask

    initial begin : stimulus
        int random_bytes;
        int k;
        sb = new();
        random_bytes = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes and both kinds of invalid lead.
        text = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        send_text();
        // Overlong zero, a lone surrogate codepoint, the top codepoint as a
        // surrogate pair, and a four-byte form past the top giving '#'.
        text = '{8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                 8'hF7, 8'hBF, 8'hBF, 8'hBF};
        send_text();
        // Truncated four-byte lead whose tail decodes again as a two-byte char.
        text = '{8'hF0, 8'hC3, 8'hA9};
        send_text();
        // Truncated lead followed by bare continuations: three '#' from one byte.
        text = '{8'hF0, 8'h80, 8'h80};
        send_text();
        // Lone lead as the whole string.
        text = '{8'hC3};
        send_text();
        wait_all_units();

        // Backpressure: result side stalls while the sender streams ASCII.
        text.delete();
        for (k = 0; k < 20; k++) text.push_back({1'b0, 7'($urandom)});
        hold_request = 1'b1;
        steady = 1'b1;
        send_text();
        steady = 1'b0;
        wait_all_units();

        // Random strings, some in no-idle bursts, some followed by a drain.
        while (random_bytes < RANDOM_BYTES) begin
            steady = ($urandom_range(0, 4) == 0);
            build_random_text();
            random_bytes += text.size();
            send_text();
            if ($urandom_range(0, 7) == 0) wait_all_units();
        end
        steady = 1'b0;
        wait_all_units();

        // Room for any stray unit to show up.
        repeat (10) @(posedge clk);

        $display("Ran %0d strings, %0d bytes in, %0d UTF-16 units checked",
                 strings, sb.bytes_in, sb.units_checked);
        $display("Covered edge leads, truncation, surrogates and a full-queue stall");
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
